>>> rtl/core/aldd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldd_pkg
// Shared types, widths and codes for the adjacent line dedup core.
// ----------------------------------------------------------------------------
package aldd_pkg;

  localparam int KEY_DEPTH  = 128;
  localparam int LINE_W     = 16;
  localparam int KEY_ADDR_W = $clog2(KEY_DEPTH);
  localparam int STORED_W   = $clog2(KEY_DEPTH + 1);
  localparam int KEY_LEN_W  = $clog2(KEY_DEPTH + 2);
  localparam int CMP_W      = (KEY_LEN_W > 8) ? KEY_LEN_W : 8;
  localparam int OUT_W      = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [1:0] OP_CHAR = 2'd0;
  localparam logic [1:0] OP_EOL  = 2'd1;
  localparam logic [1:0] OP_EOI  = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
  localparam logic [7:0] FOLD_DELTA = 8'h20;

  localparam logic [OUT_W-1:0] GROUP_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_CASE_FOLD     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_FIELDS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_CHARS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LIMITED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE   = 3'd5;

  localparam logic [1:0] MODE_ALL          = 2'd0;
  localparam logic [1:0] MODE_UNIQUE       = 2'd1;
  localparam logic [1:0] MODE_REPEAT_FIRST = 2'd2;
  localparam logic [1:0] MODE_REPEAT_ALL   = 2'd3;

  typedef enum logic [1:0] {
    PH_BLANK,
    PH_WORD,
    PH_CHAR,
    PH_KEY
  } phase_t;

  typedef enum logic [1:0] {
    CMD_KEY,
    CMD_EOL,
    CMD_EOI
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [KEY_ADDR_W-1:0] addr;
    logic [7:0]            chr;
    logic [STORED_W-1:0]   stored_len;
    logic                  trunc;
  } cmd_t;

  typedef struct packed {
    logic       case_fold;
    logic [7:0] skip_fields;
    logic [7:0] skip_chars;
    logic       width_limited;
    logic [7:0] compare_width;
    logic [1:0] select_mode;
  } cfg_t;

endpackage

>>> rtl/core/aldd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldd_in_if
// Character channel: operation code and character byte.
// ----------------------------------------------------------------------------
interface aldd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] char_code;

  modport source (output valid, operation, char_code, input ready);
  modport sink (input valid, operation, char_code, output ready);
endinterface

>>> rtl/core/aldd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldd_out_if
// Group report channel.
// ----------------------------------------------------------------------------
interface aldd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_line;
  logic [15:0] group_lines;
  logic        selected;
  logic        print_every_line;
  logic        key_truncated;

  modport source (output valid, first_line, group_lines, selected, print_every_line,
                  key_truncated, input ready);
  modport sink (input valid, first_line, group_lines, selected, print_every_line,
                key_truncated, output ready);
endinterface

>>> rtl/core/aldd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldd_ram
// Single-port RAM, read-before-write, registered read data.
// ----------------------------------------------------------------------------
module aldd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem_r[addr];
      if (we) begin
        mem_r[addr] <= wdata;
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/aldd_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldd_cmd_fifo
// Short command queue between the classifier and the key compare stage.
// ----------------------------------------------------------------------------
module aldd_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  aldd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output aldd_pkg::cmd_t head
);

  aldd_pkg::cmd_t                       slot_r [aldd_pkg::FIFO_DEPTH];
  logic [aldd_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [aldd_pkg::FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [aldd_pkg::FIFO_CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == aldd_pkg::FIFO_CNT_W'(aldd_pkg::FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/aldd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldd_front
// Classifier: field and character skipping, width limit, case folding.
// Emits key characters, end-of-line and end-of-input commands.
// ----------------------------------------------------------------------------
module aldd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  aldd_pkg::cfg_t cfg,
  input  logic           in_valid,
  input  logic [1:0]     in_operation,
  input  logic [7:0]     in_char_code,
  output logic           in_ready,
  input  logic           q_full,
  output logic           q_push,
  output aldd_pkg::cmd_t q_cmd
);

  logic                           line_open_r, line_open_nxt;
  aldd_pkg::phase_t               phase_r, phase_nxt;
  logic [7:0]                     fields_r, fields_nxt;
  logic [7:0]                     chars_r, chars_nxt;
  logic [aldd_pkg::KEY_LEN_W-1:0] cur_len_r, cur_len_nxt;

  aldd_pkg::phase_t ph;
  logic [7:0]       fl;
  logic [7:0]       cl;
  logic [7:0]       c;
  logic             go;
  logic             accept;
  logic             width_full;
  logic             trunc;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign trunc    = (cur_len_r > aldd_pkg::KEY_LEN_W'(aldd_pkg::KEY_DEPTH));
  assign width_full = cfg.width_limited &&
                      (aldd_pkg::CMP_W'(cur_len_r) >= aldd_pkg::CMP_W'(cfg.compare_width));

  always_comb begin
    line_open_nxt = line_open_r;
    phase_nxt     = phase_r;
    fields_nxt    = fields_r;
    chars_nxt     = chars_r;
    cur_len_nxt   = cur_len_r;
    ph            = line_open_r ? phase_r : aldd_pkg::PH_BLANK;
    fl            = line_open_r ? fields_r : cfg.skip_fields;
    cl            = line_open_r ? chars_r : cfg.skip_chars;
    c             = in_char_code;
    go            = 1'b1;
    q_push        = 1'b0;
    q_cmd.kind       = aldd_pkg::CMD_KEY;
    q_cmd.addr       = cur_len_r[aldd_pkg::KEY_ADDR_W-1:0];
    q_cmd.chr        = c;
    q_cmd.stored_len = trunc ? aldd_pkg::STORED_W'(aldd_pkg::KEY_DEPTH)
                             : aldd_pkg::STORED_W'(cur_len_r);
    q_cmd.trunc      = trunc;
    if (accept) begin
      unique case (in_operation)
        aldd_pkg::OP_CHAR: begin
          line_open_nxt = 1'b1;
          if ((ph == aldd_pkg::PH_BLANK || ph == aldd_pkg::PH_WORD) && fl == '0) begin
            ph = aldd_pkg::PH_CHAR;
          end
          if (ph == aldd_pkg::PH_BLANK) begin
            if (c != aldd_pkg::CHAR_SPACE) begin
              ph = aldd_pkg::PH_WORD;
            end
            go = 1'b0;
          end else if (ph == aldd_pkg::PH_WORD) begin
            if (c != aldd_pkg::CHAR_SPACE) begin
              go = 1'b0;
            end else begin
              fl = fl - 8'd1;
              if (fl != '0) begin
                ph = aldd_pkg::PH_BLANK;
                go = 1'b0;
              end else begin
                ph = aldd_pkg::PH_CHAR;
              end
            end
          end
          if (go && ph == aldd_pkg::PH_CHAR) begin
            if (cl != '0) begin
              cl = cl - 8'd1;
              go = 1'b0;
            end else begin
              ph = aldd_pkg::PH_KEY;
            end
          end
          if (go && !width_full) begin
            if (cfg.case_fold && c >= aldd_pkg::CHAR_UC_A && c <= aldd_pkg::CHAR_UC_Z) begin
              c = c + aldd_pkg::FOLD_DELTA;
            end
            q_cmd.chr = c;
            if (cur_len_r < aldd_pkg::KEY_LEN_W'(aldd_pkg::KEY_DEPTH)) begin
              q_push = 1'b1;
            end
            if (cur_len_r <= aldd_pkg::KEY_LEN_W'(aldd_pkg::KEY_DEPTH)) begin
              cur_len_nxt = cur_len_r + 1'b1;
            end
          end
          phase_nxt  = ph;
          fields_nxt = fl;
          chars_nxt  = cl;
        end
        aldd_pkg::OP_EOL: begin
          q_push        = 1'b1;
          q_cmd.kind    = aldd_pkg::CMD_EOL;
          line_open_nxt = 1'b0;
          cur_len_nxt   = '0;
        end
        aldd_pkg::OP_EOI: begin
          q_push        = 1'b1;
          q_cmd.kind    = aldd_pkg::CMD_EOI;
          line_open_nxt = 1'b0;
          cur_len_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_open_r <= 1'b0;
      phase_r     <= aldd_pkg::PH_BLANK;
      fields_r    <= '0;
      chars_r     <= '0;
      cur_len_r   <= '0;
    end else begin
      line_open_r <= line_open_nxt;
      phase_r     <= phase_nxt;
      fields_r    <= fields_nxt;
      chars_r     <= chars_nxt;
      cur_len_r   <= cur_len_nxt;
    end
  end

endmodule

>>> rtl/core/aldd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aldd_back
// Key compare and group tracking. Reads and overwrites the key store in one
// access, compares in the following cycle and reports finished groups.
// ----------------------------------------------------------------------------
module aldd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  aldd_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  aldd_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    out_first_line,
  output logic [15:0]    out_group_lines,
  output logic           out_selected,
  output logic           out_print_every_line,
  output logic           out_key_truncated
);

  logic                          b_valid_r, b_valid_nxt;
  aldd_pkg::cmd_t                b_cmd_r, b_cmd_nxt;
  logic [aldd_pkg::STORED_W-1:0] prev_len_r, prev_len_nxt;
  logic                          mism_r, mism_nxt;
  logic                          have_line_r, have_line_nxt;
  logic [aldd_pkg::LINE_W-1:0]   line_idx_r, line_idx_nxt;
  logic [aldd_pkg::LINE_W-1:0]   grp_start_r, grp_start_nxt;
  logic [aldd_pkg::OUT_W-1:0]    grp_size_r, grp_size_nxt;
  logic                          grp_ovf_r, grp_ovf_nxt;
  logic                          o_valid_r, o_valid_nxt;
  logic [aldd_pkg::OUT_W-1:0]    o_first_r, o_lines_r;
  logic                          o_sel_r, o_every_r, o_trunc_r;

  logic       ram_en;
  logic [7:0] ram_rdata;
  logic       eol_mism;
  logic       emit;
  logic       out_can;
  logic       b_done;
  logic       b_adv;
  logic       sel;

  aldd_ram #(
    .WIDTH (8),
    .DEPTH (aldd_pkg::KEY_DEPTH)
  ) u_key_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_en),
    .addr  (q_head.addr),
    .wdata (q_head.chr),
    .rdata (ram_rdata)
  );

  assign eol_mism = mism_r || (have_line_r && b_cmd_r.stored_len != prev_len_r);
  assign emit     = b_valid_r && have_line_r &&
                    (b_cmd_r.kind == aldd_pkg::CMD_EOI ||
                     (b_cmd_r.kind == aldd_pkg::CMD_EOL && eol_mism));
  assign out_can  = !o_valid_r || out_ready;
  assign b_done   = !emit || out_can;
  assign b_adv    = !b_valid_r || b_done;
  assign q_pop    = !q_empty && b_adv;
  assign ram_en   = q_pop && q_head.kind == aldd_pkg::CMD_KEY;

  always_comb begin
    case (cfg.select_mode)
      aldd_pkg::MODE_ALL:    sel = 1'b1;
      aldd_pkg::MODE_UNIQUE: sel = (grp_size_r == aldd_pkg::OUT_W'(1));
      default:               sel = (grp_size_r > aldd_pkg::OUT_W'(1));
    endcase
  end

  always_comb begin
    prev_len_nxt  = prev_len_r;
    mism_nxt      = mism_r;
    have_line_nxt = have_line_r;
    line_idx_nxt  = line_idx_r;
    grp_start_nxt = grp_start_r;
    grp_size_nxt  = grp_size_r;
    grp_ovf_nxt   = grp_ovf_r;
    b_valid_nxt   = b_valid_r;
    b_cmd_nxt     = b_cmd_r;
    o_valid_nxt   = o_valid_r && !out_ready;
    if (emit && out_can) begin
      o_valid_nxt = 1'b1;
    end
    if (b_valid_r && b_done) begin
      unique case (b_cmd_r.kind)
        aldd_pkg::CMD_KEY: begin
          if (have_line_r &&
              (aldd_pkg::STORED_W'(b_cmd_r.addr) >= prev_len_r || ram_rdata != b_cmd_r.chr)) begin
            mism_nxt = 1'b1;
          end
        end
        aldd_pkg::CMD_EOL: begin
          if (!have_line_r || eol_mism) begin
            have_line_nxt = 1'b1;
            grp_start_nxt = line_idx_r;
            grp_size_nxt  = aldd_pkg::OUT_W'(1);
            grp_ovf_nxt   = b_cmd_r.trunc;
          end else begin
            if (grp_size_r != aldd_pkg::GROUP_MAX) begin
              grp_size_nxt = grp_size_r + 1'b1;
            end
            grp_ovf_nxt = grp_ovf_r || b_cmd_r.trunc;
          end
          prev_len_nxt = b_cmd_r.stored_len;
          line_idx_nxt = line_idx_r + 1'b1;
          mism_nxt     = 1'b0;
        end
        aldd_pkg::CMD_EOI: begin
          have_line_nxt = 1'b0;
          grp_ovf_nxt   = 1'b0;
          grp_start_nxt = '0;
          grp_size_nxt  = '0;
          line_idx_nxt  = '0;
          prev_len_nxt  = '0;
          mism_nxt      = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (b_adv) begin
      b_valid_nxt = q_pop;
      b_cmd_nxt   = q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      prev_len_r  <= '0;
      mism_r      <= 1'b0;
      have_line_r <= 1'b0;
      line_idx_r  <= '0;
      grp_start_r <= '0;
      grp_size_r  <= '0;
      grp_ovf_r   <= 1'b0;
      o_valid_r   <= 1'b0;
    end else begin
      b_valid_r   <= b_valid_nxt;
      prev_len_r  <= prev_len_nxt;
      mism_r      <= mism_nxt;
      have_line_r <= have_line_nxt;
      line_idx_r  <= line_idx_nxt;
      grp_start_r <= grp_start_nxt;
      grp_size_r  <= grp_size_nxt;
      grp_ovf_r   <= grp_ovf_nxt;
      o_valid_r   <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_cmd_r <= b_cmd_nxt;
    if (emit && out_can) begin
      o_first_r <= aldd_pkg::OUT_W'(grp_start_r);
      o_lines_r <= grp_size_r;
      o_sel_r   <= sel;
      o_every_r <= sel && (cfg.select_mode == aldd_pkg::MODE_REPEAT_ALL);
      o_trunc_r <= grp_ovf_r;
    end
  end

  assign out_valid            = o_valid_r;
  assign out_first_line       = o_first_r;
  assign out_group_lines      = o_lines_r;
  assign out_selected         = o_sel_r;
  assign out_print_every_line = o_every_r;
  assign out_key_truncated    = o_trunc_r;

endmodule

>>> rtl/core/adjacent_line_dedup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacent_line_dedup_core
// Adjacent duplicate line filter over a character stream.
// Throughput: one beat per cycle unless the queue is full; each key character
//   costs one single-port read-before-write key store access and one compare.
// Report path: a closing end-of-line or end-of-input beat passes the queue
//   and the compare stage register, then the report is registered at output.
// Reset: synchronous, active low; control registers and line state clear, the
//   key store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module adjacent_line_dedup_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [aldd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aldd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  aldd_in_if.sink                           in_beat,
  aldd_out_if.source                        out_beat
);

  aldd_pkg::cfg_t cfg_r, cfg_nxt;
  aldd_pkg::cmd_t push_cmd;
  aldd_pkg::cmd_t head;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        aldd_pkg::CFG_CASE_FOLD:     cfg_nxt.case_fold     = cfg_wdata[0];
        aldd_pkg::CFG_SKIP_FIELDS:   cfg_nxt.skip_fields   = cfg_wdata[7:0];
        aldd_pkg::CFG_SKIP_CHARS:    cfg_nxt.skip_chars    = cfg_wdata[7:0];
        aldd_pkg::CFG_WIDTH_LIMITED: cfg_nxt.width_limited = cfg_wdata[0];
        aldd_pkg::CFG_COMPARE_WIDTH: cfg_nxt.compare_width = cfg_wdata[7:0];
        aldd_pkg::CFG_SELECT_MODE:   cfg_nxt.select_mode   = cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  aldd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_beat.valid),
    .in_operation (in_beat.operation),
    .in_char_code (in_beat.char_code),
    .in_ready     (in_beat.ready),
    .q_full       (full),
    .q_push       (push),
    .q_cmd        (push_cmd)
  );

  aldd_cmd_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  aldd_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_empty              (empty),
    .q_head               (head),
    .q_pop                (pop),
    .out_valid            (out_beat.valid),
    .out_ready            (out_beat.ready),
    .out_first_line       (out_beat.first_line),
    .out_group_lines      (out_beat.group_lines),
    .out_selected         (out_beat.selected),
    .out_print_every_line (out_beat.print_every_line),
    .out_key_truncated    (out_beat.key_truncated)
  );

endmodule
